FILE: hw/rtl/min_heap_timer_queue_top_macros.svh
// Assertion macros for the timer queue block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef MIN_HEAP_TIMER_QUEUE_TOP_MACROS_SVH
`define MIN_HEAP_TIMER_QUEUE_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define MHTQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MHTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/mhtq_pkg.sv
// Shared types and constants of the timer queue block.
// No dependencies; imported by the compare unit and the top level.
`default_nettype none

package mhtq_pkg;

  localparam int MAX_RESULTS = 64;
  localparam int DL_W        = 48;
  localparam int WAIT_W      = 32;
  localparam int ID_W        = 6;

  typedef enum logic [1:0] {
    F_ARM  = 2'd0,
    F_FIRE = 2'd1,
    F_TICK = 2'd2,
    F_POP  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_FULL        = 2'd1,
    ST_NOT_PRESENT = 2'd2,
    ST_EMPTY       = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_LT,
    ALU_WAIT
  } alu_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_DEC,
    S_RM0,
    S_RM1,
    S_RM2,
    S_DN0,
    S_DN1,
    S_DN2,
    S_DN3,
    S_UP0,
    S_UP1,
    S_PLACE,
    S_FIN,
    S_WAIT,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/min_heap_timer_queue_top.sv
// Timer queue: a binary min-heap of deadlines with an id-to-slot map, driven
// by a small sequencer around one shared add/compare unit. An item walks
// down or up the heap one level at a time; a tick repeats that for each
// expired timer, plus the wait on the output stage. Every step makes one
// read of the slot memories, so their single read port sets the pace. The
// block accepts an item only while its sequencer is idle. No clearing pass
// is needed after reset; slot contents are read only below the fill count
// and for ids marked present.
// Depends on mhtq_pkg, mhtq_alu and min_heap_timer_queue_top_macros.svh.
`default_nettype none
`include "min_heap_timer_queue_top_macros.svh"

module min_heap_timer_queue_top
  import mhtq_pkg::*;
#(
  parameter int SLOTS    = 64,
  parameter int ID_COUNT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // id [5:0], timeout [37:6], now [85:38], zero fill [87:86]
  input  wire logic [87:0] in_tdata,
  // func [1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // fired [0], fired_id [6:1], status [8:7], pending_count [15:9],
  // has_pending [16], next_wait [48:17], zero fill [55:49]
  output logic [55:0]      out_tdata,
  output logic             out_tlast
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int IW = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [ID_COUNT-1:0] present_r, present_nxt;
  func_t               func_r, func_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [WAIT_W-1:0]   tmo_r, tmo_nxt;
  logic [DL_W-1:0]     now_r, now_nxt;
  logic [DL_W-1:0]     dl_r, dl_nxt;
  logic [DL_W-1:0]     nd_r, nd_nxt;
  logic [ID_W-1:0]     no_r, no_nxt;
  logic [SW-1:0]       i_r, i_nxt;
  logic [SW-1:0]       start_r, start_nxt;
  logic [SW-1:0]       c_r, c_nxt;
  logic [DL_W-1:0]     cd_r, cd_nxt;
  logic [ID_W-1:0]     co_r, co_nxt;
  logic [ID_W-1:0]     vic_r, vic_nxt;
  logic [6:0]          k_r, k_nxt;
  logic                probe_r, probe_nxt;
  logic                fired_r, fired_nxt;
  status_t             status_r, status_nxt;
  logic [WAIT_W-1:0]   wait_r, wait_nxt;
  logic                more_r, more_nxt;

  logic                out_valid_r;
  logic [55:0]         out_data_r;
  logic                out_last_r;
  logic                out_load;

  // Slot memories and the id map, one write and one registered read each.
  logic [DL_W-1:0]     dl_mem  [SLOTS];
  logic [ID_W-1:0]     own_mem [SLOTS];
  logic [SW-1:0]       ids_mem [ID_COUNT];
  logic [DL_W-1:0]     rd_dl_r;
  logic [ID_W-1:0]     rd_own_r;
  logic [SW-1:0]       rd_ids_r;

  logic                mem_we;
  logic [SW-1:0]       mem_ra;
  logic [DL_W-1:0]     mem_wd_dl;
  logic [ID_W-1:0]     mem_wd_own;
  logic [IW-1:0]       ids_ra;

  alu_op_t             alu_op;
  logic [DL_W-1:0]     alu_a, alu_b, alu_res;

  logic [IW-1:0]       id_ix;
  logic                id_ok, known, in_accept;
  logic [SW:0]         c_left, c_right;
  logic [WAIT_W-1:0]   wait_w;
  logic                due;

  mhtq_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  assign id_ix   = IW'(id_r);
  assign id_ok   = 32'(id_r) < ID_COUNT;
  assign known   = id_ok && present_r[id_ix];
  assign c_left  = {i_r, 1'b1};
  assign c_right = (SW + 1)'(c_r) + (SW + 1)'(1);
  assign wait_w  = (cnt_r == '0) ? {WAIT_W{1'b1}} : alu_res[WAIT_W-1:0];
  assign due     = (cnt_r != '0) && (wait_w == '0);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dl_mem[i_r]            <= mem_wd_dl;
      own_mem[i_r]           <= mem_wd_own;
      ids_mem[IW'(mem_wd_own)] <= i_r;
    end
    rd_dl_r  <= dl_mem[mem_ra];
    rd_own_r <= own_mem[mem_ra];
    rd_ids_r <= ids_mem[ids_ra];
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    present_nxt = present_r;
    func_nxt    = func_r;
    id_nxt      = id_r;
    tmo_nxt     = tmo_r;
    now_nxt     = now_r;
    dl_nxt      = dl_r;
    nd_nxt      = nd_r;
    no_nxt      = no_r;
    i_nxt       = i_r;
    start_nxt   = start_r;
    c_nxt       = c_r;
    cd_nxt      = cd_r;
    co_nxt      = co_r;
    vic_nxt     = vic_r;
    k_nxt       = k_r;
    probe_nxt   = probe_r;
    fired_nxt   = fired_r;
    status_nxt  = status_r;
    wait_nxt    = wait_r;
    more_nxt    = more_r;
    mem_we      = 1'b0;
    mem_ra      = '0;
    mem_wd_dl   = nd_r;
    mem_wd_own  = no_r;
    ids_ra      = id_ix;
    alu_op      = ALU_LT;
    alu_a       = nd_r;
    alu_b       = cd_r;
    out_load    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          func_nxt  = func_t'(in_tuser);
          id_nxt    = in_tdata[5:0];
          tmo_nxt   = in_tdata[37:6];
          now_nxt   = in_tdata[85:38];
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        alu_op     = ALU_ADD;
        alu_a      = now_r;
        alu_b      = {{(DL_W-WAIT_W){1'b0}}, tmo_r};
        dl_nxt     = alu_res;
        fired_nxt  = 1'b0;
        probe_nxt  = 1'b0;
        more_nxt   = 1'b0;
        k_nxt      = '0;
        status_nxt = ST_OK;
        state_nxt  = S_DEC;
      end
      S_DEC: begin
        state_nxt = S_FIN;
        unique case (func_r)
          F_ARM: begin
            if (!id_ok) begin
              status_nxt = ST_NOT_PRESENT;
            end else if (known) begin
              nd_nxt    = dl_r;
              no_nxt    = id_r;
              i_nxt     = rd_ids_r;
              start_nxt = rd_ids_r;
              state_nxt = S_DN0;
            end else if (cnt_r == CW'(SLOTS)) begin
              status_nxt = ST_FULL;
            end else begin
              nd_nxt             = dl_r;
              no_nxt             = id_r;
              i_nxt              = SW'(cnt_r);
              present_nxt[id_ix] = 1'b1;
              cnt_nxt            = cnt_r + CW'(1);
              state_nxt          = S_UP0;
            end
          end
          F_FIRE: begin
            if (cnt_r == '0) begin
              status_nxt = ST_EMPTY;
            end else if (!known) begin
              status_nxt = ST_NOT_PRESENT;
            end else begin
              fired_nxt = 1'b1;
              i_nxt     = rd_ids_r;
              state_nxt = S_RM0;
            end
          end
          F_TICK: begin
            if (cnt_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              probe_nxt = 1'b1;
            end
          end
          F_POP: begin
            if (cnt_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              i_nxt     = '0;
              state_nxt = S_RM0;
            end
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_RM0: begin
        mem_ra    = i_r;
        state_nxt = S_RM1;
      end
      S_RM1: begin
        vic_nxt   = rd_own_r;
        mem_ra    = SW'(cnt_r - CW'(1));
        state_nxt = S_RM2;
      end
      S_RM2: begin
        // The last slot fills the hole and is sifted from there.
        nd_nxt                  = rd_dl_r;
        no_nxt                  = rd_own_r;
        present_nxt[IW'(vic_r)] = 1'b0;
        cnt_nxt                 = cnt_r - CW'(1);
        start_nxt               = i_r;
        state_nxt = (CW'(i_r) < cnt_r - CW'(1)) ? S_DN0 : S_FIN;
      end
      S_DN0: begin
        if (c_left >= (SW + 1)'(cnt_r)) begin
          state_nxt = (i_r != start_r) ? S_PLACE : S_UP0;
        end else begin
          c_nxt     = SW'(c_left);
          mem_ra    = SW'(c_left);
          state_nxt = S_DN1;
        end
      end
      S_DN1: begin
        cd_nxt = rd_dl_r;
        co_nxt = rd_own_r;
        if (c_right < (SW + 1)'(cnt_r)) begin
          mem_ra    = SW'(c_right);
          state_nxt = S_DN2;
        end else begin
          state_nxt = S_DN3;
        end
      end
      S_DN2: begin
        alu_a = rd_dl_r;
        alu_b = cd_r;
        if (alu_res[0]) begin
          cd_nxt = rd_dl_r;
          co_nxt = rd_own_r;
          c_nxt  = SW'(c_right);
        end
        state_nxt = S_DN3;
      end
      S_DN3: begin
        alu_a = nd_r;
        alu_b = cd_r;
        if (alu_res[0]) begin
          state_nxt = (i_r != start_r) ? S_PLACE : S_UP0;
        end else begin
          mem_we     = 1'b1;
          mem_wd_dl  = cd_r;
          mem_wd_own = co_r;
          i_nxt      = c_r;
          state_nxt  = S_DN0;
        end
      end
      S_UP0: begin
        if (i_r == '0) begin
          state_nxt = S_PLACE;
        end else begin
          mem_ra    = SW'((i_r - SW'(1)) >> 1);
          state_nxt = S_UP1;
        end
      end
      S_UP1: begin
        alu_a = rd_dl_r;
        alu_b = nd_r;
        if (alu_res[0]) begin
          state_nxt = S_PLACE;
        end else begin
          mem_we     = 1'b1;
          mem_wd_dl  = rd_dl_r;
          mem_wd_own = rd_own_r;
          i_nxt      = SW'((i_r - SW'(1)) >> 1);
          state_nxt  = S_UP0;
        end
      end
      S_PLACE: begin
        mem_we    = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        mem_ra    = '0;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        alu_op   = ALU_WAIT;
        alu_a    = rd_dl_r;
        alu_b    = now_r;
        wait_nxt = wait_w;
        if (probe_r) begin
          // First look at the root of a tick: remove it if due, else report.
          probe_nxt = 1'b0;
          more_nxt  = 1'b0;
          if (due) begin
            fired_nxt = 1'b1;
            i_nxt     = '0;
            state_nxt = S_RM0;
          end else begin
            state_nxt = S_EMIT;
          end
        end else begin
          more_nxt  = fired_r && (func_r == F_TICK) && due &&
                      (k_r < 7'(MAX_RESULTS - 1));
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_load = 1'b1;
          if (more_r) begin
            k_nxt     = k_r + 7'd1;
            i_nxt     = '0;
            state_nxt = S_RM0;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      present_r   <= '0;
      probe_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      present_r <= present_nxt;
      probe_r   <= probe_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r   <= func_nxt;
    id_r     <= id_nxt;
    tmo_r    <= tmo_nxt;
    now_r    <= now_nxt;
    dl_r     <= dl_nxt;
    nd_r     <= nd_nxt;
    no_r     <= no_nxt;
    i_r      <= i_nxt;
    start_r  <= start_nxt;
    c_r      <= c_nxt;
    cd_r     <= cd_nxt;
    co_r     <= co_nxt;
    vic_r    <= vic_nxt;
    k_r      <= k_nxt;
    fired_r  <= fired_nxt;
    status_r <= status_nxt;
    wait_r   <= wait_nxt;
    more_r   <= more_nxt;
    if (out_load) begin
      out_data_r <= {7'd0, wait_r, (cnt_r != '0), 7'(cnt_r), status_r,
                     (fired_r ? vic_r : {ID_W{1'b0}}), fired_r};
      out_last_r <= !more_r;
    end
  end

  `MHTQ_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CW'(SLOTS), "heap count above slot count")
  `MHTQ_ASSERT_NOW(a_fired_ok, out_valid_r && out_data_r[0], out_data_r[8:7] == ST_OK, "fired beat without ok status")
  `MHTQ_ASSERT_NEXT(a_rm_dec, state_r == S_RM2, cnt_r == $past(cnt_r) - CW'(1), "removal did not drop the count by one")

endmodule

`default_nettype wire

FILE: hw/rtl/mhtq_alu.sv
// Shared deadline unit: saturating add, less-than compare and saturated wait.
// Depends on mhtq_pkg for the operation codes and widths.
`default_nettype none

module mhtq_alu
  import mhtq_pkg::*;
(
  input  alu_op_t           op,
  input  logic [DL_W-1:0]   a,
  input  logic [DL_W-1:0]   b,
  output logic [DL_W-1:0]   res
);

  logic [DL_W:0] sum;
  logic [DL_W:0] diff;

  assign sum  = {1'b0, a} + {1'b0, b};
  assign diff = {1'b0, a} - {1'b0, b};

  always_comb begin
    res = '0;
    unique case (op)
      ALU_ADD: begin
        res = sum[DL_W] ? {DL_W{1'b1}} : sum[DL_W-1:0];
      end
      ALU_LT: begin
        res = {{(DL_W-1){1'b0}}, diff[DL_W]};
      end
      ALU_WAIT: begin
        // A deadline at or before now waits zero; long waits clip at the top.
        if (diff[DL_W] || diff[DL_W-1:0] == '0) begin
          res = '0;
        end else if (diff[DL_W-1:WAIT_W] != '0) begin
          res = {{(DL_W-WAIT_W){1'b0}}, {WAIT_W{1'b1}}};
        end else begin
          res = {{(DL_W-WAIT_W){1'b0}}, diff[WAIT_W-1:0]};
        end
      end
      default: res = '0;
    endcase
  end

endmodule

`default_nettype wire
